// ----- hdl/rst_polynomial_controller_unit_macros.svh -----
// ----------------------------------------------------------------------------
// RST polynomial controller assertion macros
// Shared property forms for the controller checker.
// ----------------------------------------------------------------------------
`ifndef RST_POLYNOMIAL_CONTROLLER_UNIT_MACROS_SVH
`define RST_POLYNOMIAL_CONTROLLER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define RPC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define RPC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/rpc_pkg.sv -----
// ----------------------------------------------------------------------------
// RST polynomial controller package
// Shared types, codes and sizes for the controller datapath and sequencer.
// ----------------------------------------------------------------------------
package rpc_pkg;

    localparam int RPC_MAX_TAPS = 16;
    localparam int DATA_W       = 32;
    localparam int PROD_W       = 2 * DATA_W;
    localparam int ACC_W        = 56;
    localparam int FRAC_W       = 16;
    localparam int LEN_W        = 5;
    localparam int CFG_IDX_W    = 2;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_LEN_F = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEN_G = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEN_R = 2'd2;

    typedef enum logic [1:0] {
        TBL_F = 2'd0,
        TBL_G = 2'd1,
        TBL_R = 2'd2
    } tbl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_R,
        ST_G,
        ST_F,
        ST_FLUSH,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic en;
        tbl_t tbl;
    } rd_req_t;

    typedef struct packed {
        logic valid;
        logic sub;
        logic clr;
    } mac_ctl_t;

endpackage

// ----- hdl/rpc_coef_mem.sv -----
// ----------------------------------------------------------------------------
// RST coefficient memory
// F, G and R tap tables with per-entry valid bits; one write and one
// registered read per cycle. Unwritten entries read as zero.
// ----------------------------------------------------------------------------
module rpc_coef_mem
    import rpc_pkg::*;
#(
    parameter int MAX_TAPS = RPC_MAX_TAPS,
    parameter int IDX_W    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     wr_en,
    input  logic [1:0]               wr_tbl,
    input  logic [IDX_W-1:0]         wr_addr,
    input  logic signed [DATA_W-1:0] wr_data,
    input  rd_req_t                  rd,
    input  logic [IDX_W-1:0]         rd_addr,
    output logic signed [DATA_W-1:0] rd_data
);

    logic signed [DATA_W-1:0] f_mem [MAX_TAPS];
    logic signed [DATA_W-1:0] g_mem [MAX_TAPS];
    logic signed [DATA_W-1:0] r_mem [MAX_TAPS];
    logic [MAX_TAPS-1:0]      f_vld_reg;
    logic [MAX_TAPS-1:0]      g_vld_reg;
    logic [MAX_TAPS-1:0]      r_vld_reg;
    logic signed [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= '0;
            g_vld_reg <= '0;
            r_vld_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_tbl)
                TBL_F:   f_vld_reg[wr_addr] <= 1'b1;
                TBL_G:   g_vld_reg[wr_addr] <= 1'b1;
                TBL_R:   r_vld_reg[wr_addr] <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            unique case (wr_tbl)
                TBL_F:   f_mem[wr_addr] <= wr_data;
                TBL_G:   g_mem[wr_addr] <= wr_data;
                TBL_R:   r_mem[wr_addr] <= wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            unique case (rd.tbl)
                TBL_F:   rd_data_reg <= f_vld_reg[rd_addr] ? f_mem[rd_addr] : '0;
                TBL_G:   rd_data_reg <= g_vld_reg[rd_addr] ? g_mem[rd_addr] : '0;
                TBL_R:   rd_data_reg <= r_vld_reg[rd_addr] ? r_mem[rd_addr] : '0;
                default: rd_data_reg <= '0;
            endcase
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/rpc_hist_mem.sv -----
// ----------------------------------------------------------------------------
// RST history ring
// Reference, measurement and drive delay lines kept as ring buffers with a
// shared slot valid vector; one registered read per cycle.
// ----------------------------------------------------------------------------
module rpc_hist_mem
    import rpc_pkg::*;
#(
    parameter int MAX_TAPS = RPC_MAX_TAPS,
    parameter int IDX_W    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     smp_wr_en,
    input  logic [IDX_W-1:0]         smp_wr_addr,
    input  logic signed [DATA_W-1:0] smp_ref,
    input  logic signed [DATA_W-1:0] smp_meas,
    input  logic                     drv_wr_en,
    input  logic [IDX_W-1:0]         drv_wr_addr,
    input  logic signed [DATA_W-1:0] drv_data,
    input  rd_req_t                  rd,
    input  logic [IDX_W-1:0]         rd_addr,
    output logic signed [DATA_W-1:0] rd_data
);

    logic signed [DATA_W-1:0] ref_mem  [MAX_TAPS];
    logic signed [DATA_W-1:0] meas_mem [MAX_TAPS];
    logic signed [DATA_W-1:0] drv_mem  [MAX_TAPS];
    logic [MAX_TAPS-1:0]      vld_reg;
    logic signed [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (smp_wr_en)
        begin
            vld_reg[smp_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (smp_wr_en)
        begin
            ref_mem[smp_wr_addr]  <= smp_ref;
            meas_mem[smp_wr_addr] <= smp_meas;
        end
        if (drv_wr_en)
        begin
            drv_mem[drv_wr_addr] <= drv_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            unique case (rd.tbl)
                TBL_R:   rd_data_reg <= vld_reg[rd_addr] ? ref_mem[rd_addr] : '0;
                TBL_G:   rd_data_reg <= vld_reg[rd_addr] ? meas_mem[rd_addr] : '0;
                TBL_F:   rd_data_reg <= vld_reg[rd_addr] ? drv_mem[rd_addr] : '0;
                default: rd_data_reg <= '0;
            endcase
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/rpc_mac.sv -----
// ----------------------------------------------------------------------------
// RST multiply-accumulate unit
// Shared Q16.16 multiplier with floor rescale, wide accumulator and
// 32-bit saturation of the running sum.
// ----------------------------------------------------------------------------
module rpc_mac
    import rpc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  mac_ctl_t                 ctl,
    input  logic signed [DATA_W-1:0] coef,
    input  logic signed [DATA_W-1:0] sample,
    output logic                     busy,
    output logic signed [DATA_W-1:0] drive,
    output logic                     saturated
);

    logic signed [PROD_W-1:0] prod_reg;
    logic                     p_valid_reg;
    logic                     p_sub_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [PROD_W-1:0] term_wide;
    logic signed [ACC_W-1:0]  term;
    logic [ACC_W-DATA_W:0]    acc_top;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            p_sub_reg   <= 1'b0;
        end
        else
        begin
            p_valid_reg <= ctl.valid;
            p_sub_reg   <= ctl.sub;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= coef * sample;
    end

    // floor rescale of the Q32.32 product
    assign term_wide = prod_reg >>> FRAC_W;
    assign term      = term_wide[ACC_W-1:0];

    always_ff @(posedge clk)
    begin
        if (ctl.clr)
        begin
            acc_reg <= '0;
        end
        else if (p_valid_reg)
        begin
            acc_reg <= p_sub_reg ? (acc_reg - term) : (acc_reg + term);
        end
    end

    assign acc_top   = acc_reg[ACC_W-1:DATA_W-1];
    assign saturated = !((&acc_top) || !(|acc_top));
    assign busy      = p_valid_reg;

    always_comb
    begin
        if (!saturated)
        begin
            drive = acc_reg[DATA_W-1:0];
        end
        else if (acc_reg[ACC_W-1])
        begin
            drive = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            drive = {1'b0, {(DATA_W-1){1'b1}}};
        end
    end

endmodule

// ----- hdl/rst_polynomial_controller_unit.sv -----
// ----------------------------------------------------------------------------
// RST polynomial controller unit
// Use: items enter on in_valid/in_ready. A coefficient write (op = 1) loads
// one F, G or R tap in the accept cycle and gives no result. A sample tick
// (op = 0) shifts reference and measured into the history rings, then one
// shared 32x32 multiplier walks the R, G and F taps and the saturated drive
// leaves on out_valid/out_ready with the saturated flag.
// Sequence of a tick: ST_R adds the R taps, ST_G and ST_F subtract the G
// taps and the F taps from index 1, ST_FLUSH drains the multiplier and
// ST_OUT loads the result once the output register is free; the lengths are
// capped at MAX_TAPS and the single multiply-accumulate unit takes one tap
// per cycle. in_ready returns with out_valid; a write leaves in_ready high.
// Lengths are set on the cfg channel (cfg_index 0 len_f, 1 len_g, 2 len_r),
// always ready; the user must set them only while the block is idle, which
// the block itself does not enforce.
// Reset: histories, tables and lengths read as zero; no result pending.
// Stall: the result sits in an output register; the next item is taken
// meanwhile, and a finished tick holds until the register frees.
// ----------------------------------------------------------------------------
module rst_polynomial_controller_unit
    import rpc_pkg::*;
#(
    parameter int MAX_TAPS = RPC_MAX_TAPS
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        op,
    input  logic signed [DATA_W-1:0]    reference,
    input  logic signed [DATA_W-1:0]    measured,
    input  logic [1:0]                  coef_table,
    input  logic [3:0]                  coef_index,
    input  logic signed [DATA_W-1:0]    coef_value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [DATA_W-1:0]    drive,
    output logic                        saturated,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [LEN_W-1:0]            cfg_data
);

    localparam int IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CNT_W = $clog2(MAX_TAPS + 1);

    state_t                   state_reg;
    state_t                   state_next;
    logic [CNT_W-1:0]         idx_reg;
    logic [CNT_W-1:0]         idx_next;
    logic [IDX_W-1:0]         wp_reg;
    logic [IDX_W-1:0]         wp_next;
    logic [LEN_W-1:0]         len_f_reg;
    logic [LEN_W-1:0]         len_g_reg;
    logic [LEN_W-1:0]         len_r_reg;
    logic                     iss_valid_reg;
    logic                     iss_sub_reg;
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] drive_reg;
    logic                     sat_reg;

    logic                     tick_acc;
    logic                     wr_acc;
    logic                     coef_wr_en;
    logic                     issue;
    logic                     sub;
    logic                     clr;
    logic                     out_load;
    tbl_t                     tbl;
    rd_req_t                  rd;
    mac_ctl_t                 mac_ctl;
    logic [CNT_W-1:0]         n_f;
    logic [CNT_W-1:0]         n_g;
    logic [CNT_W-1:0]         n_r;
    logic [IDX_W:0]           ring_sum;
    logic [IDX_W-1:0]         hist_addr;
    logic signed [DATA_W-1:0] coef_q;
    logic signed [DATA_W-1:0] hist_q;
    logic                     mac_busy;
    logic signed [DATA_W-1:0] mac_drive;
    logic                     mac_sat;

    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign tick_acc  = in_valid && in_ready && (op == OP_TICK);
    assign wr_acc    = in_valid && in_ready && (op == OP_WRITE);
    assign coef_wr_en = wr_acc && (int'(coef_index) < MAX_TAPS);

    assign n_f = (int'(len_f_reg) > MAX_TAPS) ? CNT_W'(MAX_TAPS) : CNT_W'(len_f_reg);
    assign n_g = (int'(len_g_reg) > MAX_TAPS) ? CNT_W'(MAX_TAPS) : CNT_W'(len_g_reg);
    assign n_r = (int'(len_r_reg) > MAX_TAPS) ? CNT_W'(MAX_TAPS) : CNT_W'(len_r_reg);

    // age i lives at slot wp + i, wrapped
    assign ring_sum  = (IDX_W+1)'(wp_reg) + (IDX_W+1)'(idx_reg[IDX_W-1:0]);
    assign hist_addr = (ring_sum >= (IDX_W+1)'(MAX_TAPS))
                     ? IDX_W'(ring_sum - (IDX_W+1)'(MAX_TAPS))
                     : IDX_W'(ring_sum);

    assign wp_next = (wp_reg == '0) ? IDX_W'(MAX_TAPS - 1) : (wp_reg - IDX_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        issue      = 1'b0;
        sub        = 1'b0;
        clr        = 1'b0;
        out_load   = 1'b0;
        tbl        = TBL_R;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (tick_acc)
                begin
                    clr        = 1'b1;
                    idx_next   = '0;
                    state_next = ST_R;
                end
            end
            ST_R:
            begin
                tbl = TBL_R;
                if (idx_reg < n_r)
                begin
                    issue    = 1'b1;
                    idx_next = idx_reg + CNT_W'(1);
                end
                else
                begin
                    idx_next   = '0;
                    state_next = ST_G;
                end
            end
            ST_G:
            begin
                tbl = TBL_G;
                sub = 1'b1;
                if (idx_reg < n_g)
                begin
                    issue    = 1'b1;
                    idx_next = idx_reg + CNT_W'(1);
                end
                else
                begin
                    idx_next   = CNT_W'(1);
                    state_next = ST_F;
                end
            end
            ST_F:
            begin
                tbl = TBL_F;
                sub = 1'b1;
                if (idx_reg < n_f)
                begin
                    issue    = 1'b1;
                    idx_next = idx_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!iss_valid_reg && !mac_busy)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            wp_reg        <= '0;
            iss_valid_reg <= 1'b0;
            iss_sub_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            iss_valid_reg <= issue;
            iss_sub_reg   <= sub;
            if (tick_acc)
            begin
                wp_reg <= wp_next;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_f_reg <= '0;
            len_g_reg <= '0;
            len_r_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LEN_F: len_f_reg <= cfg_data;
                REG_LEN_G: len_g_reg <= cfg_data;
                REG_LEN_R: len_r_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            drive_reg <= mac_drive;
            sat_reg   <= mac_sat;
        end
    end

    assign rd.en  = issue;
    assign rd.tbl = tbl;

    assign mac_ctl.valid = iss_valid_reg;
    assign mac_ctl.sub   = iss_sub_reg;
    assign mac_ctl.clr   = clr;

    rpc_coef_mem #(
        .MAX_TAPS (MAX_TAPS),
        .IDX_W    (IDX_W)
    ) u_coef (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (coef_wr_en),
        .wr_tbl   (coef_table),
        .wr_addr  (IDX_W'(coef_index)),
        .wr_data  (coef_value),
        .rd       (rd),
        .rd_addr  (idx_reg[IDX_W-1:0]),
        .rd_data  (coef_q)
    );

    rpc_hist_mem #(
        .MAX_TAPS (MAX_TAPS),
        .IDX_W    (IDX_W)
    ) u_hist (
        .clk         (clk),
        .rst_n       (rst_n),
        .smp_wr_en   (tick_acc),
        .smp_wr_addr (wp_next),
        .smp_ref     (reference),
        .smp_meas    (measured),
        .drv_wr_en   (out_load),
        .drv_wr_addr (wp_reg),
        .drv_data    (mac_drive),
        .rd          (rd),
        .rd_addr     (hist_addr),
        .rd_data     (hist_q)
    );

    rpc_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (mac_ctl),
        .coef      (coef_q),
        .sample    (hist_q),
        .busy      (mac_busy),
        .drive     (mac_drive),
        .saturated (mac_sat)
    );

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;
    assign saturated = sat_reg;

endmodule

// ----- hdl/rpc_checker.sv -----
// ----------------------------------------------------------------------------
// RST polynomial controller checker
// Port-level properties of the controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "rst_polynomial_controller_unit_macros.svh"

module rpc_checker
    import rpc_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     op,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic signed [DATA_W-1:0] drive,
    input logic                     saturated
);

    `RPC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(drive) && $stable(saturated), "stalled result changed")
    `RPC_ASSERT_NOW(a_sat_clip, out_valid && saturated,
        drive == 32'sh7FFF_FFFF || drive == 32'sh8000_0000, "saturated drive not clipped")
    `RPC_ASSERT_NEXT(a_tick_busy, in_valid && in_ready && op == OP_TICK,
        !in_ready, "tick accepted without going busy")
    `RPC_ASSERT_NEXT(a_write_silent, in_valid && in_ready && op == OP_WRITE && !out_valid,
        !out_valid, "coefficient write produced a result")

endmodule

bind rst_polynomial_controller_unit rpc_checker u_rpc_checker (.*);

// ----- bench/rst_polynomial_controller_unit_tb.sv -----
// ----------------------------------------------------------------------------
// RST polynomial controller unit testbench
// Drives coefficient writes and sample ticks through the item handshake and
// sets the tap lengths on the register channel between phases. A tracker
// class keeps its own copy of the delay lines, tap tables and lengths. It
// predicts each drive sample and its saturation flag, then checks every
// returned item in order. Both sides idle at random, and the receiver holds
// off once for a long stretch.
// ----------------------------------------------------------------------------
module rst_polynomial_controller_unit_tb;
    import rpc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 3 * RPC_MAX_TAPS + 12;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 80;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    localparam logic [1:0] TBL_NONE = 2'd3;
    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7fffffff;
    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh80000000;
    localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh00010000;
    localparam logic signed [DATA_W-1:0] Q_HALF = 32'sh00008000;

    typedef struct {
        logic                     op;
        logic signed [DATA_W-1:0] reference;
        logic signed [DATA_W-1:0] measured;
        logic [1:0]               coef_table;
        logic [3:0]               coef_index;
        logic signed [DATA_W-1:0] coef_value;
    } ctl_item_t;

    typedef struct {
        logic signed [DATA_W-1:0] drive;
        logic                     saturated;
    } drive_sample_t;

    class drive_tracker;
        logic signed [DATA_W-1:0] f_taps[RPC_MAX_TAPS];
        logic signed [DATA_W-1:0] g_taps[RPC_MAX_TAPS];
        logic signed [DATA_W-1:0] r_taps[RPC_MAX_TAPS];
        logic signed [DATA_W-1:0] ref_line[RPC_MAX_TAPS];
        logic signed [DATA_W-1:0] meas_line[RPC_MAX_TAPS];
        logic signed [DATA_W-1:0] drive_line[RPC_MAX_TAPS];
        logic [LEN_W-1:0]         len_f;
        logic [LEN_W-1:0]         len_g;
        logic [LEN_W-1:0]         len_r;
        drive_sample_t            expected_drives[$];
        int                       mismatches;

        function new();
            foreach (f_taps[i])
            begin
                f_taps[i] = '0;
                g_taps[i] = '0;
                r_taps[i] = '0;
                ref_line[i] = '0;
                meas_line[i] = '0;
                drive_line[i] = '0;
            end
            len_f = '0;
            len_g = '0;
            len_r = '0;
            mismatches = 0;
        endfunction

        function void set_length(logic [CFG_IDX_W-1:0] idx, logic [LEN_W-1:0] val);
            case (idx)
                REG_LEN_F: len_f = val;
                REG_LEN_G: len_g = val;
                REG_LEN_R: len_r = val;
                default: ;
            endcase
        endfunction

        function int tap_count(logic [LEN_W-1:0] len);
            return (len > RPC_MAX_TAPS) ? RPC_MAX_TAPS : int'(len);
        endfunction

        function longint scaled_product(logic signed [DATA_W-1:0] a,
                                        logic signed [DATA_W-1:0] b);
            longint p;
            p = longint'(a) * longint'(b);
            return p >>> FRAC_W;
        endfunction

        function void take_item(ctl_item_t it);
            longint        acc;
            drive_sample_t res;
            if (it.op == OP_WRITE)
            begin
                case (it.coef_table)
                    TBL_F: f_taps[it.coef_index] = it.coef_value;
                    TBL_G: g_taps[it.coef_index] = it.coef_value;
                    TBL_R: r_taps[it.coef_index] = it.coef_value;
                    default: ;
                endcase
                return;
            end
            for (int i = RPC_MAX_TAPS - 1; i > 0; i--)
            begin
                ref_line[i] = ref_line[i-1];
                meas_line[i] = meas_line[i-1];
                drive_line[i] = drive_line[i-1];
            end
            ref_line[0] = it.reference;
            meas_line[0] = it.measured;
            drive_line[0] = '0;
            acc = 0;
            for (int i = 0; i < tap_count(len_r); i++)
                acc += scaled_product(r_taps[i], ref_line[i]);
            for (int i = 0; i < tap_count(len_g); i++)
                acc -= scaled_product(g_taps[i], meas_line[i]);
            for (int i = 1; i < tap_count(len_f); i++)
                acc -= scaled_product(f_taps[i], drive_line[i]);
            if (acc > longint'(Q_MAX))
            begin
                res.drive = Q_MAX;
                res.saturated = 1'b1;
            end
            else if (acc < longint'(Q_MIN))
            begin
                res.drive = Q_MIN;
                res.saturated = 1'b1;
            end
            else
            begin
                res.drive = acc[DATA_W-1:0];
                res.saturated = 1'b0;
            end
            drive_line[0] = res.drive;
            expected_drives.push_back(res);
        endfunction

        function void check_drive(logic signed [DATA_W-1:0] d, logic s);
            drive_sample_t want;
            if (expected_drives.size() == 0)
            begin
                mismatches++;
                $display("%0t unexpected drive item: drive %h saturated %b", $time, d, s);
                return;
            end
            want = expected_drives.pop_front();
            if (d !== want.drive)
            begin
                mismatches++;
                $display("%0t drive mismatch: expected %h actual %h", $time, want.drive, d);
            end
            if (s !== want.saturated)
            begin
                mismatches++;
                $display("%0t saturated mismatch: expected %b actual %b",
                         $time, want.saturated, s);
            end
        endfunction

        function int pending();
            return expected_drives.size();
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic                     op;
    logic signed [DATA_W-1:0] reference;
    logic signed [DATA_W-1:0] measured;
    logic [1:0]               coef_table;
    logic [3:0]               coef_index;
    logic signed [DATA_W-1:0] coef_value;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [DATA_W-1:0] drive;
    logic                     saturated;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [LEN_W-1:0]         cfg_data;

    drive_tracker tracker = new();
    bit           rx_no_idle = 1'b0;
    bit           rx_long_hold = 1'b0;
    int           cycle_count = 0;

    rst_polynomial_controller_unit i_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int draw_gap(bit no_idle);
        return no_idle ? 0 : int'($urandom_range(0, 10));
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_sample();
        int v;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 3))
                    0: v = Q_MAX;
                    1: v = Q_MIN;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
            1, 2: v = $urandom;
            default:
            begin
                v = $urandom_range(0, 32'h100000);
                v = v - 32'h80000;
            end
        endcase
        return v;
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_coef();
        int v;
        if ($urandom_range(0, 7) == 0)
            return rand_sample();
        v = $urandom_range(0, 2 * Q_ONE);
        return v - Q_ONE;
    endfunction

    function automatic ctl_item_t tick_item(logic signed [DATA_W-1:0] r,
                                            logic signed [DATA_W-1:0] m);
        ctl_item_t it;
        it.op = OP_TICK;
        it.reference = r;
        it.measured = m;
        it.coef_table = 2'($urandom_range(0, 3));
        it.coef_index = 4'($urandom_range(0, 15));
        it.coef_value = $urandom;
        return it;
    endfunction

    function automatic ctl_item_t coef_item(logic [1:0] tbl, logic [3:0] idx,
                                            logic signed [DATA_W-1:0] val);
        ctl_item_t it;
        it.op = OP_WRITE;
        it.reference = $urandom;
        it.measured = $urandom;
        it.coef_table = tbl;
        it.coef_index = idx;
        it.coef_value = val;
        return it;
    endfunction

    function automatic ctl_item_t rand_item();
        if ($urandom_range(0, 9) < 7)
            return tick_item(rand_sample(), rand_sample());
        return coef_item(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)), rand_coef());
    endfunction

    task automatic send_item(input ctl_item_t it, input int gap);
        repeat (gap)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= it.op;
        reference <= it.reference;
        measured <= it.measured;
        coef_table <= it.coef_table;
        coef_index <= it.coef_index;
        coef_value <= it.coef_value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        tracker.take_item(it);
    endtask

    task automatic program_lengths(input logic [LEN_W-1:0] lf, input logic [LEN_W-1:0] lg,
                                   input logic [LEN_W-1:0] lr, input bit poke_spare);
        logic [CFG_IDX_W-1:0] idx_list[$];
        logic [LEN_W-1:0]     val_list[$];
        idx_list = '{REG_LEN_F, REG_LEN_G, REG_LEN_R};
        val_list = '{lf, lg, lr};
        if (poke_spare)
        begin
            idx_list.push_back(REG_SPARE);
            val_list.push_back(LEN_W'($urandom_range(0, 31)));
        end
        foreach (idx_list[k])
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx_list[k];
            cfg_data <= val_list[k];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            tracker.set_length(idx_list[k], val_list[k]);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int n;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            n = draw_gap(rx_no_idle);
            if (rx_long_hold)
            begin
                n = HOLD_CYCLES;
                rx_long_hold = 1'b0;
            end
            repeat (n)
            begin
                out_ready <= 1'b0;
                @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            tracker.check_drive(drive, saturated);
        end
    end

    initial
    begin
        ctl_item_t        directed[$];
        logic [LEN_W-1:0] lens[3];
        bit               no_idle;

        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_TICK;
        reference = '0;
        measured = '0;
        coef_table = '0;
        coef_index = '0;
        coef_value = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero lengths out of reset: drive stays zero
        send_item(tick_item(Q_MAX, Q_MIN), 0);
        in_valid <= 1'b0;
        wait_idle();
        program_lengths(LEN_W'(RPC_MAX_TAPS), LEN_W'(RPC_MAX_TAPS), LEN_W'(RPC_MAX_TAPS),
                        1'b1);

        directed.push_back(coef_item(TBL_R, 0, Q_ONE));
        directed.push_back(coef_item(TBL_G, 0, Q_HALF));
        directed.push_back(coef_item(TBL_F, 1, Q_MIN));
        directed.push_back(coef_item(TBL_NONE, 0, Q_MAX));
        directed.push_back(coef_item(TBL_F, 0, Q_MAX));
        directed.push_back(coef_item(TBL_R, 15, Q_MAX));
        directed.push_back(coef_item(TBL_G, 15, -1));
        directed.push_back(tick_item(Q_MAX, Q_MIN));
        directed.push_back(tick_item(Q_MIN, Q_MAX));
        directed.push_back(tick_item(0, 0));
        directed.push_back(tick_item(-1, 0));
        directed.push_back(tick_item(1, 0));
        directed.push_back(coef_item(TBL_R, 0, 1));
        directed.push_back(coef_item(TBL_F, 1, 0));
        directed.push_back(tick_item(-1, 0));
        directed.push_back(tick_item(1, -1));
        directed.push_back(tick_item(Q_MIN, Q_MIN));
        directed.push_back(tick_item(0, 0));
        directed.push_back(coef_item(TBL_F, 15, Q_ONE));
        directed.push_back(coef_item(TBL_R, 15, 0));
        directed.push_back(tick_item(Q_MAX, Q_MAX));
        directed.push_back(tick_item(0, Q_MIN));
        foreach (directed[k])
            send_item(directed[k], draw_gap(1'b0));
        in_valid <= 1'b0;

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            foreach (lens[k])
            begin
                case (p)
                    0: lens[k] = LEN_W'(RPC_MAX_TAPS);
                    1: lens[k] = '0;
                    2: lens[k] = '1;
                    3: lens[k] = LEN_W'(1);
                    default: lens[k] = LEN_W'($urandom_range(0, 31));
                endcase
            end
            program_lengths(lens[0], lens[1], lens[2], p == 4);
            no_idle = (p == 0) || (p == 5);
            rx_no_idle = no_idle;
            if (p == 2)
                rx_long_hold = 1'b1;
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_item(rand_item(), draw_gap(no_idle));
            in_valid <= 1'b0;
        end

        wait_idle();
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
